// ===== hdl/led_pad_pwm_dimmer_core_macros.svh =====
`ifndef LED_PAD_PWM_DIMMER_CORE_MACROS_SVH
`define LED_PAD_PWM_DIMMER_CORE_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define LPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpd assertion failed");

// next-cycle implication
`define LPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpd assertion failed");

`endif

// ===== hdl/lpd_pkg.sv =====
package lpd_pkg;

    localparam int PADS         = 4;
    localparam int LEDS_PER_PAD = 16;
    localparam int PAD_W        = 2;
    localparam int LED_W        = 4;
    localparam int WORD_W       = 16;
    localparam int INT_W        = 8;
    localparam int PHASE_W      = 7;
    localparam int CFG_W        = 3;
    localparam int CFG_IDX_W    = 1;

    localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(99);
    localparam logic [WORD_W-1:0]  WORD_RESET  = '1;
    localparam logic [CFG_W-1:0]   PADS_RESET  = CFG_W'(1);
    localparam logic [CFG_W-1:0]   PORT_RESET  = CFG_W'(2);
    localparam logic [CFG_W-1:0]   PADS_MAX    = CFG_W'(PADS);

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_PATTERN   = 2'd1,
        OP_INTENSITY = 2'd2,
        OP_ENABLE    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PADS_IN_USE = 1'd0,
        REG_SPI_PORT    = 1'd1
    } reg_idx_t;

    typedef logic [LEDS_PER_PAD-1:0][INT_W-1:0] intens_row_t;

endpackage

// ===== hdl/lpd_if.sv =====
interface lpd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [1:0]  pad_index;
    logic [3:0]  led_index;
    logic [15:0] value;

    modport source (output valid, output operation, output pad_index,
                    output led_index, output value, input ready);
    modport sink   (input valid, input operation, input pad_index,
                    input led_index, input value, output ready);
endinterface

interface lpd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] led_word;
    logic [1:0]  word_pad;
    logic [2:0]  port_number;
    logic        last_word;

    modport source (output valid, output led_word, output word_pad,
                    output port_number, output last_word, input ready);
    modport sink   (input valid, input led_word, input word_pad,
                    input port_number, input last_word, output ready);
endinterface

// ===== hdl/lpd_intensity_ram.sv =====
module lpd_intensity_ram (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [lpd_pkg::PAD_W-1:0]         wr_row,
    input  logic [lpd_pkg::LED_W-1:0]         wr_col,
    input  logic [lpd_pkg::INT_W-1:0]         wr_data,
    input  logic                              rd_en,
    input  logic [lpd_pkg::PAD_W-1:0]         rd_row,
    output lpd_pkg::intens_row_t              rd_data
);

    lpd_pkg::intens_row_t                      mem_reg [lpd_pkg::PADS];
    logic [lpd_pkg::PADS-1:0][lpd_pkg::LEDS_PER_PAD-1:0] valid_reg;
    lpd_pkg::intens_row_t                      rd_data_reg;
    logic [lpd_pkg::LEDS_PER_PAD-1:0]          rd_valid_reg;

    // byte-wide write into a row-wide memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_row][wr_col] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_row];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_row][wr_col] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_row];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < lpd_pkg::LEDS_PER_PAD; j++)
        begin
            rd_data[j] = rd_valid_reg[j] ? rd_data_reg[j] : '0;
        end
    end

endmodule

// ===== hdl/lpd_mask_unit.sv =====
module lpd_mask_unit (
    input  lpd_pkg::intens_row_t               intensity,
    input  logic [lpd_pkg::WORD_W-1:0]         pattern,
    input  logic                               enable,
    input  logic [lpd_pkg::PHASE_W-1:0]        phase,
    output logic [lpd_pkg::WORD_W-1:0]         word
);

    logic [lpd_pkg::LEDS_PER_PAD-1:0] lit;

    // one comparator per led, all side by side
    always_comb
    begin
        for (int j = 0; j < lpd_pkg::LEDS_PER_PAD; j++)
        begin
            lit[j] = ({1'b0, phase} <= intensity[j]);
        end
        word = enable ? (pattern & lit) : '0;
    end

endmodule

// ===== hdl/led_pad_pwm_dimmer_core.sv =====
// write items do not leave the idle state; the block is ready again on the next cycle
// a tick walks the served pads from the highest down to pad 0, then flushes the held-back word:
// each pad needs an intensity memory read step and a compare/emit step, which waits while the output is stalled
// reset clears patterns, intensities, enables, phases and sets the last sent word to all ones
`include "led_pad_pwm_dimmer_core_macros.svh"

module led_pad_pwm_dimmer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    lpd_in_if.sink                           in_ch,
    lpd_out_if.source                        out_ch,
    input  logic                             cfg_we,
    input  logic [lpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpd_pkg::CFG_W-1:0]        cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FLUSH
    } state_t;

    state_t                              state_reg;
    logic [lpd_pkg::CFG_W-1:0]           pads_in_use_reg;
    logic [lpd_pkg::CFG_W-1:0]           spi_port_reg;
    logic [lpd_pkg::WORD_W-1:0]          pattern_reg [lpd_pkg::PADS];
    logic [lpd_pkg::PADS-1:0]            enable_reg;
    logic [lpd_pkg::PHASE_W-1:0]         phase_reg [lpd_pkg::PADS];
    logic [lpd_pkg::WORD_W-1:0]          last_sent_reg;
    logic [lpd_pkg::PAD_W-1:0]           cur_reg;

    // word held back until we know whether it is the last of the tick
    logic                                pend_valid_reg;
    logic [lpd_pkg::WORD_W-1:0]          pend_word_reg;
    logic [lpd_pkg::PAD_W-1:0]           pend_pad_reg;

    logic                                out_valid_reg;
    logic [lpd_pkg::WORD_W-1:0]          out_word_reg;
    logic [lpd_pkg::PAD_W-1:0]           out_pad_reg;
    logic [lpd_pkg::CFG_W-1:0]           out_port_reg;
    logic                                out_last_reg;

    lpd_pkg::op_t                        op;
    logic                                accept;
    logic                                pad_ok;
    logic [lpd_pkg::CFG_W-1:0]           n_sat;
    logic                                ram_wr_en;
    lpd_pkg::intens_row_t                row_data;
    logic [lpd_pkg::WORD_W-1:0]          word;
    logic                                need_emit;
    logic                                slot_free;
    logic                                stall;
    logic                                load_out;

    assign op        = lpd_pkg::op_t'(in_ch.operation);
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept    = in_ch.valid && in_ch.ready;
    assign pad_ok    = ({1'b0, in_ch.pad_index} < 3'(lpd_pkg::PADS));
    assign n_sat     = (pads_in_use_reg > lpd_pkg::PADS_MAX) ? lpd_pkg::PADS_MAX
                                                            : pads_in_use_reg;
    assign ram_wr_en = accept && (op == lpd_pkg::OP_INTENSITY) && pad_ok;
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign need_emit = (word != last_sent_reg);
    assign stall     = need_emit && pend_valid_reg && !slot_free;
    // output register takes a new item this cycle
    assign load_out  = ((state_reg == ST_EVAL) && !stall && need_emit && pend_valid_reg) ||
                       ((state_reg == ST_FLUSH) && pend_valid_reg && slot_free);

    lpd_intensity_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ram_wr_en),
        .wr_row  (in_ch.pad_index),
        .wr_col  (in_ch.led_index),
        .wr_data (in_ch.value[lpd_pkg::INT_W-1:0]),
        .rd_en   (state_reg == ST_READ),
        .rd_row  (cur_reg),
        .rd_data (row_data)
    );

    lpd_mask_unit u_mask (
        .intensity (row_data),
        .pattern   (pattern_reg[cur_reg]),
        .enable    (enable_reg[cur_reg]),
        .phase     (phase_reg[cur_reg]),
        .word      (word)
    );

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.led_word    = out_word_reg;
    assign out_ch.word_pad    = out_pad_reg;
    assign out_ch.port_number = out_port_reg;
    assign out_ch.last_word   = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pads_in_use_reg <= lpd_pkg::PADS_RESET;
            spi_port_reg    <= lpd_pkg::PORT_RESET;
            enable_reg      <= '0;
            last_sent_reg   <= lpd_pkg::WORD_RESET;
            cur_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            pend_word_reg   <= '0;
            pend_pad_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_word_reg    <= '0;
            out_pad_reg     <= '0;
            out_port_reg    <= '0;
            out_last_reg    <= 1'b0;
            for (int i = 0; i < lpd_pkg::PADS; i++)
            begin
                pattern_reg[i] <= '0;
                phase_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (lpd_pkg::reg_idx_t'(cfg_index))
                    lpd_pkg::REG_PADS_IN_USE: pads_in_use_reg <= cfg_data;
                    lpd_pkg::REG_SPI_PORT:    spi_port_reg    <= cfg_data;
                endcase
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (op)
                            lpd_pkg::OP_TICK:
                            begin
                                if (n_sat != '0)
                                begin
                                    cur_reg   <= lpd_pkg::PAD_W'(n_sat - 3'd1);
                                    state_reg <= ST_READ;
                                end
                            end
                            lpd_pkg::OP_PATTERN:
                            begin
                                if (pad_ok)
                                begin
                                    pattern_reg[in_ch.pad_index] <= in_ch.value;
                                end
                            end
                            lpd_pkg::OP_ENABLE:
                            begin
                                if (pad_ok)
                                begin
                                    enable_reg[in_ch.pad_index] <= |in_ch.value;
                                end
                            end
                            lpd_pkg::OP_INTENSITY:
                            begin
                                // the memory takes this write
                            end
                        endcase
                    end
                end

                ST_READ:
                begin
                    state_reg <= ST_EVAL;
                end

                ST_EVAL:
                begin
                    if (!stall)
                    begin
                        if (need_emit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_word_reg  <= pend_word_reg;
                                out_pad_reg   <= pend_pad_reg;
                                out_port_reg  <= spi_port_reg;
                                out_last_reg  <= 1'b0;
                            end
                            last_sent_reg  <= word;
                            pend_valid_reg <= 1'b1;
                            pend_word_reg  <= word;
                            pend_pad_reg   <= cur_reg;
                        end
                        phase_reg[cur_reg] <= (phase_reg[cur_reg] == lpd_pkg::PHASE_LAST)
                                              ? '0 : phase_reg[cur_reg] + 7'd1;
                        if (cur_reg == '0)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                        else
                        begin
                            cur_reg   <= cur_reg - 2'd1;
                            state_reg <= ST_READ;
                        end
                    end
                end

                ST_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (slot_free)
                    begin
                        out_word_reg   <= pend_word_reg;
                        out_pad_reg    <= pend_pad_reg;
                        out_port_reg   <= spi_port_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // a held-back word never survives the end of a tick
    `LPD_ASSERT_NOW(a_no_pend_idle, state_reg == ST_IDLE, !pend_valid_reg)
    // a word that is not the last of its tick always has a successor waiting
    `LPD_ASSERT_NOW(a_more_follows, out_valid_reg && !out_last_reg, pend_valid_reg)
    // phase counter wraps before reaching 100
    `LPD_ASSERT_NOW(a_phase_range, state_reg == ST_EVAL,
                    phase_reg[cur_reg] <= lpd_pkg::PHASE_LAST)
    // every read is followed by an evaluation of the same pad
    `LPD_ASSERT_NEXT(a_read_eval, state_reg == ST_READ, state_reg == ST_EVAL && $stable(cur_reg))

endmodule
